// ===== rtl/cre_pkg.sv =====
// ----------------------------------------------------------------------------
// cre_pkg
// Shared types, constants and helpers for the character range expander.
// ----------------------------------------------------------------------------
package cre_pkg;

  typedef logic [7:0] char_t;

  localparam char_t DASH_CHAR = 8'h2D;
  localparam char_t UPPER_LO  = 8'h41;
  localparam char_t UPPER_HI  = 8'h5A;
  localparam char_t LOWER_LO  = 8'h61;
  localparam char_t LOWER_HI  = 8'h7A;

  // request to the letter stepper
  typedef struct packed {
    char_t cur;
    char_t target;
    logic  up;
  } step_req_t;

  // stepper answer: next letter and whether it reached the target
  typedef struct packed {
    char_t nxt;
    logic  hit;
  } step_rsp_t;

  function automatic logic is_letter(input char_t c);
    logic upper;
    logic lower;
    upper = (c >= UPPER_LO) && (c <= UPPER_HI);
    lower = (c >= LOWER_LO) && (c <= LOWER_HI);
    return upper || lower;
  endfunction

endpackage

// ===== rtl/cre_if.sv =====
// ----------------------------------------------------------------------------
// cre_if
// Valid/ready stream interfaces for the input bytes and the expanded bytes.
// ----------------------------------------------------------------------------
interface cre_in_if;
  logic          valid;
  logic          ready;
  cre_pkg::char_t in_char;
  logic          in_final;

  modport source (output valid, output in_char, output in_final, input ready);
  modport sink   (input valid, input in_char, input in_final, output ready);
endinterface

interface cre_out_if;
  logic          valid;
  logic          ready;
  cre_pkg::char_t out_char;
  logic          out_final;

  modport source (output valid, output out_char, output out_final, input ready);
  modport sink   (input valid, input out_char, input out_final, output ready);
endinterface

// ===== rtl/char_range_expander_top.sv =====
// ----------------------------------------------------------------------------
// char_range_expander_top
// Expands letter ranges written with a dash, one input byte per transfer.
//
// A dash that is neither first nor last in the string and sits between two
// ASCII letters is replaced by the letters strictly between them, counting up
// or down; equal letters give nothing and every other byte passes unchanged.
// A mid-string dash is held until the next byte arrives, so that transfer
// produces nothing. A byte that releases a held dash unchanged sends the
// dash, then the byte. A byte that closes a range of k letters is accepted,
// then the single letter stepper produces the k letters one by one, and the
// step that reaches the target sends the byte itself. Output stalls hold
// these steps; while a result waits in the output register nothing new is
// accepted, and a new byte can enter in the same cycle that the waiting
// result transfers.
// ----------------------------------------------------------------------------
module char_range_expander_top (
  input  logic      clk,
  input  logic      rst,
  cre_in_if.sink    text,
  cre_out_if.source expanded
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_OWN   = 2'd2;

  logic [1:0]     state;
  logic [1:0]     state_next;

  // string context
  cre_pkg::char_t prev;
  logic           dash_held;
  cre_pkg::char_t before_dash;
  logic           start;

  // range walk and the byte that follows it
  cre_pkg::char_t cur;
  cre_pkg::char_t target;
  logic           up;
  cre_pkg::char_t pend_char;
  logic           pend_final;

  // output register
  logic           ov;
  cre_pkg::char_t ochar;
  logic           ofinal;

  logic           slot_free;
  logic           accept;
  logic           emit;
  cre_pkg::char_t emit_char;
  logic           emit_final;

  logic           is_range;
  logic           range_walk;
  logic           dash_out;
  logic           own_out;

  cre_pkg::step_req_t step_req;
  cre_pkg::step_rsp_t step_rsp;

  assign slot_free = !ov || expanded.ready;
  assign text.ready = (state == ST_IDLE) && slot_free;
  assign accept = text.valid && text.ready;

  assign is_range   = dash_held && cre_pkg::is_letter(before_dash)
                      && cre_pkg::is_letter(text.in_char);
  assign range_walk = is_range && (before_dash != text.in_char);
  assign dash_out   = dash_held && !is_range;
  assign own_out    = !((text.in_char == cre_pkg::DASH_CHAR) && !start && !text.in_final);

  assign step_req.cur    = cur;
  assign step_req.target = target;
  assign step_req.up     = up;

  cre_step_unit u_step (
    .req (step_req),
    .rsp (step_rsp)
  );

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_char  = text.in_char;
    emit_final = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (range_walk) begin
            state_next = ST_RANGE;
          end else if (dash_out) begin
            emit      = 1'b1;
            emit_char = cre_pkg::DASH_CHAR;
            if (own_out) begin
              state_next = ST_OWN;
            end
          end else if (own_out) begin
            emit       = 1'b1;
            emit_char  = text.in_char;
            emit_final = text.in_final;
          end
        end
      end
      ST_RANGE: begin
        if (slot_free) begin
          emit = 1'b1;
          if (step_rsp.hit) begin
            emit_char  = pend_char;
            emit_final = pend_final;
            state_next = ST_IDLE;
          end else begin
            emit_char = step_rsp.nxt;
          end
        end
      end
      ST_OWN: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_char  = pend_char;
          emit_final = pend_final;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ov        <= 1'b0;
      prev      <= '0;
      dash_held <= 1'b0;
      before_dash <= '0;
      start     <= 1'b1;
    end else begin
      state <= state_next;
      if (emit) begin
        ov <= 1'b1;
      end else if (expanded.ready) begin
        ov <= 1'b0;
      end
      if (accept) begin
        if (text.in_final) begin
          prev        <= '0;
          dash_held   <= 1'b0;
          before_dash <= '0;
          start       <= 1'b1;
        end else begin
          prev      <= text.in_char;
          start     <= 1'b0;
          dash_held <= !own_out;
          if (!own_out) begin
            before_dash <= prev;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ochar  <= emit_char;
      ofinal <= emit_final;
    end
    if (accept) begin
      cur        <= before_dash;
      target     <= text.in_char;
      up         <= before_dash < text.in_char;
      pend_char  <= text.in_char;
      pend_final <= text.in_final;
    end else if (state == ST_RANGE && slot_free) begin
      cur <= step_rsp.nxt;
    end
  end

  assign expanded.valid     = ov;
  assign expanded.out_char  = ochar;
  assign expanded.out_final = ofinal;

  // the walk stops before it lands on the closing letter
  a_walk_short: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RANGE) |-> (cur != target))
    else $error("range walk passed its target");

  // a final byte puts the context back to the start of a string
  a_final_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && text.in_final) |=> (start && !dash_held))
    else $error("context not restored after final byte");

  // a dash is never held at the start of a string
  a_held_not_start: assert property (@(posedge clk) disable iff (rst)
    dash_held |-> !start)
    else $error("dash held at string start");

  // the released dash still occupies the output while its byte waits
  a_own_after_dash: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OWN) |-> ov)
    else $error("pending byte without preceding dash");

endmodule

// ===== rtl/cre_step_unit.sv =====
// ----------------------------------------------------------------------------
// cre_step_unit
// Letter stepper: moves one code up or down and compares with the target.
// ----------------------------------------------------------------------------
module cre_step_unit (
  input  cre_pkg::step_req_t req,
  output cre_pkg::step_rsp_t rsp
);

  cre_pkg::char_t nxt;

  assign nxt      = req.up ? (req.cur + 8'd1) : (req.cur - 8'd1);
  assign rsp.nxt  = nxt;
  assign rsp.hit  = (nxt == req.target);

endmodule

// ===== sim/tb_char_range_expander_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_range_expander_top
// Streams strings into the range expander and checks every output byte
// against a local predictor, under random stalls on both channels and in a phase without stalls.
// ----------------------------------------------------------------------------
module tb_char_range_expander_top;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASE_ITEMS  = 120;

  typedef struct {
    cre_pkg::char_t ch;
    logic           fin;
  } text_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cre_in_if  text_if ();
  cre_out_if exp_if ();

  char_range_expander_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .text     (text_if),
    .expanded (exp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_byte_t pending_text[$];
  text_byte_t expected_bytes[$];

  // predictor state
  cre_pkg::char_t prev_byte;
  logic           dash_pending;
  cre_pkg::char_t left_byte;
  logic           at_start;

  int src_idle_pct;
  int snk_idle_pct;
  int error_count;
  int items_queued;
  int strings_sent;
  int ranges_seen;
  int bytes_checked;
  int stall_cycles;
  logic in_done;

  function automatic logic alpha(input cre_pkg::char_t c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic cre_pkg::char_t rand_letter();
    if ($urandom_range(0, 1) == 0)
      return cre_pkg::char_t'(8'h41 + $urandom_range(0, 25));
    return cre_pkg::char_t'(8'h61 + $urandom_range(0, 25));
  endfunction

  task automatic push_out(input cre_pkg::char_t c, input logic fin);
    text_byte_t b;
    b.ch  = c;
    b.fin = fin;
    expected_bytes.insert(expected_bytes.size(), b);
  endtask

  // expected output for one accepted input byte
  task automatic expand_byte(input cre_pkg::char_t c, input logic fin);
    cre_pkg::char_t cur;
    if (dash_pending) begin
      if (alpha(left_byte) && alpha(c)) begin
        ranges_seen++;
        cur = left_byte;
        if (cur < c) cur++;
        else if (cur > c) cur--;
        while (cur != c) begin
          push_out(cur, 1'b0);
          if (cur < c) cur++;
          else cur--;
        end
      end else begin
        push_out(cre_pkg::DASH_CHAR, 1'b0);
      end
      dash_pending = 1'b0;
    end
    if (c == cre_pkg::DASH_CHAR && !at_start && !fin) begin
      dash_pending = 1'b1;
      left_byte    = prev_byte;
    end else begin
      push_out(c, fin);
    end
    if (fin) begin
      prev_byte    = '0;
      dash_pending = 1'b0;
      left_byte    = '0;
      at_start     = 1'b1;
      strings_sent++;
    end else begin
      prev_byte = c;
      at_start  = 1'b0;
    end
  endtask

  task automatic add_byte(input cre_pkg::char_t c, input logic fin);
    text_byte_t b;
    b.ch  = c;
    b.fin = fin;
    pending_text.insert(pending_text.size(), b);
    items_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      add_byte(cre_pkg::char_t'(s[i]), i == s.len() - 1);
  endtask

  // mostly letter-dash-letter chains, some strings of arbitrary bytes
  task automatic rand_string();
    int             len;
    int             kind;
    cre_pkg::char_t c;
    len  = $urandom_range(1, 9);
    kind = $urandom_range(0, 9);
    for (int i = 0; i < len; i++) begin
      if (kind < 7) begin
        if (i % 2 == 1)
          c = ($urandom_range(0, 9) < 8) ? cre_pkg::DASH_CHAR
                                           : cre_pkg::char_t'($urandom_range(1, 255));
        else
          c = ($urandom_range(0, 9) < 8) ? rand_letter()
                                           : cre_pkg::char_t'($urandom_range(1, 255));
      end else begin
        c = ($urandom_range(0, 3) == 0) ? cre_pkg::DASH_CHAR
                                          : cre_pkg::char_t'($urandom_range(1, 255));
      end
      add_byte(c, i == len - 1);
    end
  endtask

  // sender holds off until every expected byte has come out
  task automatic drain();
    while (pending_text.size() > 0 || text_if.valid) @(posedge clk);
    while (expected_bytes.size() > 0) @(posedge clk);
  endtask

  // input side: note the transfer and predict
  always @(posedge clk) begin
    if (rst) begin
      in_done <= 1'b0;
    end else begin
      in_done <= text_if.valid && text_if.ready;
      if (text_if.valid && text_if.ready)
        expand_byte(text_if.in_char, text_if.in_final);
    end
  end

  // driver
  always @(negedge clk) begin
    text_byte_t b;
    if (rst) begin
      text_if.valid <= 1'b0;
    end else if (!text_if.valid || in_done) begin
      if (pending_text.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        b = pending_text.pop_front();
        text_if.valid    <= 1'b1;
        text_if.in_char  <= b.ch;
        text_if.in_final <= b.fin;
      end else begin
        text_if.valid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (rst) exp_if.ready <= 1'b0;
    else exp_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    text_byte_t want;
    if (!rst && exp_if.valid && exp_if.ready) begin
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected output: out_char %h out_final %b",
               exp_if.out_char, exp_if.out_final);
        error_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (exp_if.out_char !== want.ch) begin
          $error("out_char mismatch: expected %h actual %h", want.ch, exp_if.out_char);
          error_count++;
        end
        if (exp_if.out_final !== want.fin) begin
          $error("out_final mismatch: expected %b actual %b", want.fin, exp_if.out_final);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (text_if.valid && text_if.ready) || (exp_if.valid && exp_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_char_range_expander_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    text_if.valid    = 1'b0;
    text_if.in_char  = 8'h01;
    text_if.in_final = 1'b0;
    exp_if.ready     = 1'b0;
    prev_byte        = '0;
    dash_pending     = 1'b0;
    left_byte        = '0;
    at_start         = 1'b1;
    error_count      = 0;
    items_queued     = 0;
    strings_sent     = 0;
    ranges_seen      = 0;
    bytes_checked    = 0;
    stall_cycles     = 0;
    src_idle_pct     = 30;
    snk_idle_pct     = 48;

    repeat (5) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // directed strings
    push_text("-");
    push_text("a-e");
    push_text("z-A");
    push_text("a-a");
    push_text("-b");
    push_text("c-");
    add_byte(8'h61, 1'b0);
    add_byte(cre_pkg::DASH_CHAR, 1'b0);
    add_byte(8'h01, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(cre_pkg::DASH_CHAR, 1'b0);
    add_byte(8'h61, 1'b1);
    push_text("a--b");
    drain();

    items_queued = 0;
    while (items_queued < PHASE_ITEMS / 2) rand_string();
    drain();
    while (items_queued < PHASE_ITEMS) rand_string();
    drain();

    src_idle_pct = 48;
    snk_idle_pct = 30;
    items_queued = 0;
    while (items_queued < PHASE_ITEMS) rand_string();
    drain();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    items_queued = 0;
    while (items_queued < PHASE_ITEMS) rand_string();
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d strings, %0d letter ranges, %0d output bytes checked",
             strings_sent, ranges_seen, bytes_checked);
    $display("stall mixes: sender 30/receiver 48, sender 48/receiver 30, no stalls");
    if (error_count == 0) begin
      $display("tb_char_range_expander_top: PASS");
    end else begin
      $display("tb_char_range_expander_top: FAIL");
    end
    $finish;
  end

endmodule
